// ===== rtl/core/bfgb_pkg.sv =====
// ----------------------------------------------------------------------------
// bfgb_pkg
// Shared types and constants of the glyph blit unit: the input and result
// words, configuration register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bfgb_pkg;

  // Field widths fixed by the interface.
  localparam int GlyphW    = 8;
  localparam int CellXW    = 7;
  localparam int CellYW    = 6;
  localparam int ColorW    = 32;
  localparam int AtlasIdxW = 14;
  localparam int PixelXW   = 10;
  localparam int PixelYW   = 9;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  // Default geometry.
  localparam int CellWDef      = 8;
  localparam int CellHDef      = 8;
  localparam int AtlasWMaxDef  = 128;
  localparam int AtlasHMaxDef  = 128;
  localparam int ScreenWDef    = 640;
  localparam int ScreenHDef    = 480;

  // Register reset values.
  localparam logic [7:0]        AtlasWidthRst  = 8'd128;
  localparam logic [7:0]        FirstGlyphRst  = 8'd0;
  localparam logic [ColorW-1:0] TranspColorRst = '0;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ATLAS_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_GLYPH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TRANSP_COLOR = 2'd2;

  // Command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // One input word.
  typedef struct packed {
    logic                 command;
    logic [GlyphW-1:0]    glyph;
    logic [CellXW-1:0]    cell_x;
    logic [CellYW-1:0]    cell_y;
    logic [ColorW-1:0]    fg_color;
    logic [AtlasIdxW-1:0] atlas_index;
    logic [ColorW-1:0]    atlas_pixel;
  } in_word_t;

  // One result word: a framebuffer pixel write.
  typedef struct packed {
    logic [PixelXW-1:0] pixel_x;
    logic [PixelYW-1:0] pixel_y;
    logic [ColorW-1:0]  color;
    logic               write_enable;
    logic               last;
  } out_word_t;

  // Result of the tile divider.
  typedef struct packed {
    logic [GlyphW-1:0] quot;
    logic [GlyphW-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_font_glyph_blit_unit.sv =====
// A load word writes one opacity bit of the mask memory in the accept cycle; busy stays low.
// A draw word keeps busy high through 8 divider steps, address setup and a bounds check,
// then one mask read per cycle from the mask memory, one pixel write each.
// A draw with a glyph below the first glyph or an atlas narrower than a cell skips setup.
// A mask read passes the read stage, then the output stage; writes cannot be stalled.
// Synchronous active-low reset clears control and configuration; the mask memory is not cleared.
// ----------------------------------------------------------------------------
// bitmap_font_glyph_blit_unit
// Character cell renderer: keeps a one-bit opacity mask of a font atlas and
// draws a glyph cell as a raster of framebuffer pixel writes.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_font_glyph_blit_unit #(
  parameter int CELL_W      = bfgb_pkg::CellWDef,
  parameter int CELL_H      = bfgb_pkg::CellHDef,
  parameter int ATLAS_W_MAX = bfgb_pkg::AtlasWMaxDef,
  parameter int ATLAS_H_MAX = bfgb_pkg::AtlasHMaxDef,
  parameter int SCREEN_W    = bfgb_pkg::ScreenWDef,
  parameter int SCREEN_H    = bfgb_pkg::ScreenHDef
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire bfgb_pkg::in_word_t                in_data,
  output logic                                   out_valid,
  output bfgb_pkg::out_word_t                    out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bfgb_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [bfgb_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int MaskDepth = ATLAS_W_MAX * ATLAS_H_MAX;
  localparam int MemAW     = $clog2(MaskDepth);
  localparam int AddrWideW = $clog2(256 * CELL_H * 256 + 512) + 1;
  localparam int AyW       = $clog2(256 * CELL_H);
  localparam int PxW       = $clog2(128 * CELL_W) + 1;
  localparam int PyW       = $clog2(64 * CELL_H) + 1;
  localparam int ColW      = $clog2(CELL_W);
  localparam int RowW      = $clog2(CELL_H);
  localparam int GW        = bfgb_pkg::GlyphW;
  localparam int CW        = bfgb_pkg::ColorW;
  localparam logic [7:0] TprRst = 8'(bfgb_pkg::AtlasWidthRst / CELL_W);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // Configuration registers.
  logic [7:0]    aw_r;
  logic [7:0]    tpr_r;
  logic [GW-1:0] first_r;
  logic [CW-1:0] transp_r;

  // Draw context.
  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  logic                 ok_r;
  logic [CW-1:0]        fg_r;
  logic [PxW-1:0]       cx_base_r;
  logic [PyW-1:0]       cy_base_r;
  logic [AyW-1:0]       ay0_r;
  logic [7:0]           ax0_r;
  logic [AddrWideW-1:0] row_addr_r;
  logic [ColW-1:0]      c_r;
  logic [RowW-1:0]      r_r;

  // Read stage and output stage.
  logic                 s1_valid_r;
  logic [PxW-1:0]       s1_px_r;
  logic [PyW-1:0]       s1_py_r;
  logic                 s1_en_r;
  logic                 s1_last_r;
  logic                 rd_bit_r;
  logic                 out_valid_r;
  bfgb_pkg::out_word_t  out_r;

  // Mask memory.
  logic                 mask_mem [MaskDepth];

  logic                 accept;
  logic                 is_draw;
  logic                 draw_ok;
  logic [GW-1:0]        tile;
  logic [31:0]          ld_idx_w;
  logic                 mem_we;
  logic [MemAW-1:0]     mem_waddr;
  logic [AddrWideW-1:0] rd_addr;
  logic [PxW-1:0]       px;
  logic [PyW-1:0]       py;
  logic                 pix_last;
  logic                 row_end;
  logic [31:0]          last_addr;
  logic                 div_start;
  logic                 div_done;
  bfgb_pkg::div_res_t   div_res;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_draw   = (in_data.command == bfgb_pkg::CMD_DRAW);

  // Tile number and early validity of a draw.
  assign tile      = in_data.glyph - first_r;
  assign draw_ok   = (in_data.glyph >= first_r) && (tpr_r != 8'd0);
  assign div_start = accept && is_draw && draw_ok;

  // Load path: write the opacity bit directly.
  assign ld_idx_w  = 32'(in_data.atlas_index);
  assign mem_waddr = ld_idx_w[MemAW-1:0];
  assign mem_we    = accept && !is_draw && (ld_idx_w < 32'(MaskDepth));

  // Emit-phase addressing.
  assign rd_addr   = row_addr_r + AddrWideW'(c_r);
  assign px        = cx_base_r + PxW'(c_r);
  assign py        = cy_base_r + PyW'(r_r);
  assign row_end   = (c_r == ColW'(CELL_W - 1));
  assign pix_last  = row_end && (r_r == RowW'(CELL_H - 1));

  // Address of the tile's last pixel for the bounds check.
  assign last_addr = 32'(row_addr_r) + (32'(CELL_H - 1) * 32'(aw_r)) + 32'(CELL_W - 1);

  bfgb_tile_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tile),
    .divisor  (tpr_r),
    .done     (div_done),
    .res      (div_res)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r     <= bfgb_pkg::AtlasWidthRst;
      tpr_r    <= TprRst;
      first_r  <= bfgb_pkg::FirstGlyphRst;
      transp_r <= bfgb_pkg::TranspColorRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfgb_pkg::CFG_ATLAS_WIDTH: begin
          aw_r  <= cfg_data[7:0];
          tpr_r <= 8'(cfg_data[7:0] / CELL_W);
        end
        bfgb_pkg::CFG_FIRST_GLYPH:  first_r  <= cfg_data[GW-1:0];
        bfgb_pkg::CFG_TRANSP_COLOR: transp_r <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Mask memory: one write port for loads, one registered read for draws.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_waddr] <= (in_data.atlas_pixel != transp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      rd_bit_r <= mask_mem[rd_addr[MemAW-1:0]];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_draw) begin
          state_nxt = draw_ok ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (pix_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Draw context: capture, tile origin, row base and emit counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
      c_r  <= '0;
      r_r  <= '0;
    end else begin
      if (accept && is_draw) begin
        ok_r <= draw_ok;
        c_r  <= '0;
        r_r  <= '0;
      end else if (state_r == ST_CHK) begin
        ok_r <= ok_r && (last_addr < 32'(MaskDepth));
      end else if (state_r == ST_EMIT) begin
        if (row_end) begin
          c_r <= '0;
          r_r <= r_r + 1'b1;
        end else begin
          c_r <= c_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_draw) begin
      fg_r      <= in_data.fg_color;
      cx_base_r <= PxW'(32'(in_data.cell_x) * CELL_W);
      cy_base_r <= PyW'(32'(in_data.cell_y) * CELL_H);
    end
    if (div_done) begin
      ay0_r <= AyW'(32'(div_res.quot) * CELL_H);
      ax0_r <= 8'(32'(div_res.rem) * CELL_W);
    end
    if (state_r == ST_MUL) begin
      row_addr_r <= AddrWideW'(ay0_r) * AddrWideW'(aw_r) + AddrWideW'(ax0_r);
    end else if (state_r == ST_EMIT && row_end) begin
      row_addr_r <= row_addr_r + AddrWideW'(aw_r);
    end
  end

  // Read stage: pixel position and enable travel beside the mask read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= (state_r == ST_EMIT);
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      s1_px_r   <= px;
      s1_py_r   <= py;
      s1_en_r   <= ok_r && (32'(px) < 32'(SCREEN_W)) && (32'(py) < 32'(SCREEN_H));
      s1_last_r <= pix_last;
    end
  end

  // Output stage: one pixel write word per cycle.
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_r.pixel_x      <= s1_px_r[bfgb_pkg::PixelXW-1:0];
      out_r.pixel_y      <= s1_py_r[bfgb_pkg::PixelYW-1:0];
      out_r.color        <= fg_r;
      out_r.write_enable <= s1_en_r && rd_bit_r;
      out_r.last         <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // The last write of a cell is always preceded by other writes of the same cell.
  a_last_follows_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> $past(out_valid))
    else $error("last pixel write without preceding writes");

  // An accepted draw makes the unit busy in the next cycle.
  a_draw_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.command == bfgb_pkg::CMD_DRAW)) |=> busy)
    else $error("draw accepted but unit not busy");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider result outside divide phase");

  // Loads never write the mask memory while a draw is reading it.
  a_no_load_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("mask write during draw");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bfgb_tile_div.sv =====
// ----------------------------------------------------------------------------
// bfgb_tile_div
// Restoring divider for the tile number: splits it into tile row (quotient)
// and tile column (remainder), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfgb_tile_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic [bfgb_pkg::GlyphW-1:0]     dividend,
  input  wire logic [bfgb_pkg::GlyphW-1:0]     divisor,
  output logic                                 done,
  output bfgb_pkg::div_res_t                   res
);

  localparam int W    = bfgb_pkg::GlyphW;
  localparam int CntW = $clog2(W + 1);

  logic            run_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [W-1:0]    quo_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dvs_r;

  logic [W:0]      shifted;
  logic            ge;
  logic [W-1:0]    rem_nxt;

  // One trial subtraction per cycle.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? W'(shifted - {1'b0, dvs_r}) : shifted[W-1:0];
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire
